### hw/rtl/itsc_pkg.sv
`default_nettype none
package itsc_pkg;
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_POTENTIAL = 3'd1;
	localparam logic [2:0] PH_DIRECTION = 3'd2;
	localparam logic [2:0] PH_CONFIRMED = 3'd3;
	localparam logic [2:0] PH_SETTLE    = 3'd4;

	localparam logic [1:0] RSN_NONE   = 2'd0;
	localparam logic [1:0] RSN_LONG   = 2'd1;
	localparam logic [1:0] RSN_CHANGE = 2'd2;
	localparam logic [1:0] RSN_SHARP  = 2'd3;

	localparam logic [2:0] DIR_NONE = 3'd0;
	localparam logic [2:0] DIR_PX   = 3'd1;
	localparam logic [2:0] DIR_NX   = 3'd2;
	localparam logic [2:0] DIR_PY   = 3'd3;
	localparam logic [2:0] DIR_NY   = 3'd4;
	localparam logic [2:0] DIR_PZ   = 3'd5;
	localparam logic [2:0] DIR_NZ   = 3'd6;

	localparam logic [2:0] REG_ACCEL   = 3'd0;
	localparam logic [2:0] REG_GYRO    = 3'd1;
	localparam logic [2:0] REG_MAXDUR  = 3'd2;
	localparam logic [2:0] REG_SETTLE  = 3'd3;
	localparam logic [2:0] REG_REBOUND = 3'd4;
	localparam logic [2:0] REG_RATIO   = 3'd5;
	localparam logic [2:0] REG_SHARP   = 3'd6;
	localparam logic [2:0] REG_GAP     = 3'd7;

	localparam logic [7:0] CHANGE_LIMIT  = 8'd3;
	localparam logic [7:0] CONSIST_LIMIT = 8'd3;
endpackage
`default_nettype wire

### hw/rtl/itsc_mag.sv
`default_nettype none
// Magnitude of a 3-axis vector: squares accumulated over three 16x16
// products, then a restoring square root that settles two radicand bits per cycle.
module itsc_mag
	import itsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] abs_a,
	input  wire logic [15:0] abs_b,
	input  wire logic [15:0] abs_c,
	output logic             done,
	output logic [15:0]      mag
);
	logic [2:0]  sq_cnt_q;
	logic [4:0]  rt_cnt_q;
	logic        busy_q;
	logic        rt_q;
	logic [33:0] sum_q;
	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [15:0] op;
	logic [31:0] prod;
	logic [17:0] trial;
	logic [17:0] shifted;

	always_comb begin
		unique case (sq_cnt_q)
			3'd0: op = abs_a;
			3'd1: op = abs_b;
			default: op = abs_c;
		endcase
		prod = op * op;
		shifted = {rem_q[15:0], rad_q[31:30]};
		trial = {root_q, 2'b01};
	end

	assign mag = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rt_q <= 1'b0;
			done <= 1'b0;
			sq_cnt_q <= '0;
			rt_cnt_q <= '0;
		end else begin
			done <= !start && !busy_q && rt_q && (rt_cnt_q == 5'd15);
			if (start) begin
				busy_q <= 1'b1;
				sq_cnt_q <= '0;
			end else if (busy_q) begin
				if (sq_cnt_q == 3'd2) begin
					busy_q <= 1'b0;
					rt_q <= 1'b1;
					rt_cnt_q <= '0;
				end
				sq_cnt_q <= sq_cnt_q + 3'd1;
			end else if (rt_q) begin
				rt_cnt_q <= rt_cnt_q + 5'd1;
				if (rt_cnt_q == 5'd15)
					rt_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= '0;
		end else if (busy_q) begin
			sum_q <= sum_q + {2'b00, prod};
			if (sq_cnt_q == 3'd2) begin
				rad_q <= sum_q[31:0] + prod;
				rem_q <= '0;
				root_q <= '0;
			end
		end else if (rt_q) begin
			rad_q <= {rad_q[29:0], 2'b00};
			if (shifted >= trial) begin
				rem_q <= shifted - trial;
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q <= shifted;
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/imu_tap_swing_classifier.sv
`default_nettype none
// IMU tap / swing classifier.
// s_axis carries one sample per transaction; m_axis returns exactly one
// result per sample. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while the block is idle, and the block itself does not enforce this.
// After acceptance a sample passes through a start strobe, serial squaring and
// the square-root iterations, one per root bit, in each of the two magnitude
// units (run side by side), a registered done, then the serial ratio products
// and a decision step before m_axis_tvalid rises.
// The root iterations take most of this path. One sample is in work at a time;
// s_axis_tready is low from acceptance until the result has been taken, so a
// new sample is accepted only after the previous result has been taken.
// Reset clears the phase machine, event state, motion flag and restores the
// register defaults. When the receiver stalls, the result is held on m_axis
// and no further sample is accepted.
module imu_tap_swing_classifier
	import itsc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms, clear_motion, pad
	input  wire logic [135:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tap_found, swing_found, swing_reason, phase, motion_flag,
	// peak_magnitude, event_duration_ms
	output logic [55:0]       m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAG  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [15:0] acc_thr_q, gyr_thr_q, maxdur_q, settle_q, rebound_q, sharp_q;
	logic [7:0]  ratio_q;
	logic [14:0] gap_q;

	logic [2:0]  phase_q, dir_q, st_q;
	logic [31:0] start_q, taptime_q, now_q;
	logic [15:0] peak_q, prevmag_q;
	logic [23:0] sum_q;
	logic [7:0]  cnt_q, cons_q, chg_q;
	logic        motion_q, clr_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic [15:0] gx_q, gy_q, gz_q;
	logic [1:0]  mstep_q;
	logic [31:0] rhs_q;
	logic [39:0] rhs_acc_q;
	logic [55:0] out_q;

	logic        a_done, g_done, a_fin_q, g_fin_q;
	logic [15:0] amag, gmag;
	logic [15:0] uax, uay, uaz, ugx, ugy, ugz;
	logic        in_acc_d;

	function automatic logic [15:0] uabs(input logic [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

	assign uax = uabs(ax_q);
	assign uay = uabs(ay_q);
	assign uaz = uabs(az_q);
	assign ugx = gx_q;
	assign ugy = gy_q;
	assign ugz = gz_q;

	wire in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = out_q;

	itsc_mag u_amag (.clk, .arst_n, .start(in_acc_d), .abs_a(uax), .abs_b(uay),
		.abs_c(uaz), .done(a_done), .mag(amag));
	itsc_mag u_gmag (.clk, .arst_n, .start(in_acc_d), .abs_a(ugx), .abs_b(ugy),
		.abs_c(ugz), .done(g_done), .mag(gmag));

	// Direction pick.
	logic [2:0]  cur, dir;
	logic [15:0] ca, la, dd;
	function automatic logic [15:0] axis_abs(input logic [2:0] d, input logic [15:0] x,
		input logic [15:0] y, input logic [15:0] z);
		priority if (d == DIR_PX || d == DIR_NX) return x;
		else if (d == DIR_PY || d == DIR_NY) return y;
		else if (d == DIR_PZ || d == DIR_NZ) return z;
		else return 16'd0;
	endfunction
	always_comb begin
		priority if (uax >= uay && uax >= uaz)
			cur = (!ax_q[15] && ax_q != 0) ? DIR_PX : DIR_NX;
		else if (uay >= uax && uay >= uaz)
			cur = (!ay_q[15] && ay_q != 0) ? DIR_PY : DIR_NY;
		else
			cur = (!az_q[15] && az_q != 0) ? DIR_PZ : DIR_NZ;
		ca = axis_abs(cur, uax, uay, uaz);
		la = axis_abs(dir_q, uax, uay, uaz);
		dd = (ca > la) ? ca - la : la - ca;
		dir = cur;
		if (cur != dir_q && dir_q >= DIR_PX && dir_q <= DIR_NZ && {1'b0, dd} < {2'b0, gap_q})
			dir = dir_q;
	end

	// Decision logic.
	logic [31:0] elapsed;
	logic [15:0] delta;
	logic [16:0] a2, g2;
	logic [39:0] lhs;
	logic [18:0] p5;
	logic [18:0] t6;
	logic        ok, sust;
	logic [7:0]  chg_n, cons_n;
	always_comb begin
		elapsed = now_q - start_q;
		delta = (amag > prevmag_q) ? amag - prevmag_q : prevmag_q - amag;
		a2 = {amag, 1'b0};
		g2 = {gmag, 1'b0};
		sust = a2 > {1'b0, acc_thr_q} && g2 > {1'b0, gyr_thr_q};
		lhs = {4'd0, rhs_q, 4'd0};
		p5 = {3'b0, peak_q} + {1'b0, peak_q, 2'b0};
		t6 = {2'b0, acc_thr_q, 1'b0} + {1'b0, acc_thr_q, 2'b0};
		ok = (lhs > rhs_acc_q) && (p5 > t6) && (delta > sharp_q);
		chg_n = (chg_q != 8'd255) ? chg_q + 8'd1 : chg_q;
		cons_n = (cons_q != 8'd255) ? cons_q + 8'd1 : cons_q;
	end

	// Result word, built in the decision cycle from current and next state.
	logic        tap, swing;
	logic [1:0]  rsn;
	logic [31:0] dur;
	logic [2:0]  ph_n;
	logic        mot_n;
	logic [15:0] pk_n;
	always_comb begin
		tap = 1'b0; swing = 1'b0; rsn = RSN_NONE; dur = '0;
		ph_n = phase_q; mot_n = motion_q && !clr_q; pk_n = peak_q;
		unique case (phase_q)
			PH_IDLE: if (amag > acc_thr_q && gmag > gyr_thr_q) begin
				ph_n = PH_POTENTIAL; pk_n = amag;
			end
			PH_POTENTIAL: begin
				if (elapsed > {16'd0, maxdur_q}) begin
					swing = 1'b1; rsn = RSN_LONG; dur = elapsed; ph_n = PH_IDLE;
					mot_n = 1'b1;
				end else if (dir != dir_q && chg_n >= CHANGE_LIMIT) begin
					swing = 1'b1; rsn = RSN_CHANGE; dur = elapsed; ph_n = PH_IDLE;
					mot_n = 1'b1;
				end else if (sust) begin
					if (amag > peak_q) pk_n = amag;
					if (cons_n >= CONSIST_LIMIT) ph_n = PH_DIRECTION;
				end else begin
					ph_n = PH_IDLE;
				end
			end
			PH_DIRECTION: begin
				dur = elapsed; mot_n = 1'b1;
				if (ok) begin
					tap = 1'b1; ph_n = PH_CONFIRMED;
				end else begin
					swing = 1'b1; rsn = RSN_SHARP; ph_n = PH_IDLE;
				end
			end
			PH_CONFIRMED: ph_n = PH_SETTLE;
			PH_SETTLE: if ((now_q - taptime_q) > {16'd0, settle_q} && amag < rebound_q)
				ph_n = PH_IDLE;
			default: ph_n = PH_IDLE;
		endcase
	end

	// Serial ratio products: lhs part peak*count (16x8), rhs sum*ratio (24x8).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			in_acc_d <= 1'b0;
			a_fin_q <= 1'b0;
			g_fin_q <= 1'b0;
			mstep_q <= '0;
			acc_thr_q <= 16'd4096; gyr_thr_q <= 16'd2048; maxdur_q <= 16'd150;
			settle_q <= 16'd200; rebound_q <= 16'd2048; ratio_q <= 8'd24;
			sharp_q <= 16'd512; gap_q <= 15'd256;
			phase_q <= PH_IDLE; start_q <= '0; taptime_q <= '0; peak_q <= '0;
			sum_q <= '0; cnt_q <= '0; dir_q <= DIR_NONE; cons_q <= '0; chg_q <= '0;
			prevmag_q <= '0; motion_q <= 1'b0;
		end else begin
			in_acc_d <= in_acc;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACCEL:   acc_thr_q <= cfg_data;
					REG_GYRO:    gyr_thr_q <= cfg_data;
					REG_MAXDUR:  maxdur_q <= cfg_data;
					REG_SETTLE:  settle_q <= cfg_data;
					REG_REBOUND: rebound_q <= cfg_data;
					REG_RATIO:   ratio_q <= cfg_data[7:0];
					REG_SHARP:   sharp_q <= cfg_data;
					REG_GAP:     gap_q <= cfg_data[14:0];
				endcase
			end
			unique case (st_q)
				ST_IDLE: if (in_acc) begin
					st_q <= ST_MAG;
					a_fin_q <= 1'b0;
					g_fin_q <= 1'b0;
				end
				ST_MAG: begin
					if (a_done) a_fin_q <= 1'b1;
					if (g_done) g_fin_q <= 1'b1;
					if ((a_fin_q || a_done) && (g_fin_q || g_done)) begin
						st_q <= ST_MUL;
						mstep_q <= '0;
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd2) st_q <= ST_DEC;
				end
				ST_DEC: begin
					st_q <= ST_OUT;
					motion_q <= mot_n;
					prevmag_q <= amag;
					unique case (phase_q)
						PH_IDLE: if (amag > acc_thr_q && gmag > gyr_thr_q) begin
							start_q <= now_q; peak_q <= amag; sum_q <= {8'd0, amag};
							cnt_q <= 8'd1; dir_q <= dir; cons_q <= 8'd1; chg_q <= '0;
							phase_q <= PH_POTENTIAL;
						end
						PH_POTENTIAL: begin
							if (elapsed > {16'd0, maxdur_q}) begin
								phase_q <= PH_IDLE;
							end else if (dir != dir_q && chg_n >= CHANGE_LIMIT) begin
								chg_q <= chg_n; dir_q <= dir;
								phase_q <= PH_IDLE;
							end else begin
								if (dir != dir_q) begin
									chg_q <= chg_n; dir_q <= dir;
								end
								if (sust) begin
									if (cnt_q != 8'd255) begin
										cnt_q <= cnt_q + 8'd1;
										sum_q <= sum_q + {8'd0, amag};
									end
									if (amag > peak_q) peak_q <= amag;
									// After a direction update dir equals the stored one.
									cons_q <= cons_n;
									if (cons_n >= CONSIST_LIMIT) phase_q <= PH_DIRECTION;
								end else begin
									phase_q <= PH_IDLE;
								end
							end
						end
						PH_DIRECTION: begin
							if (ok) begin
								taptime_q <= now_q; phase_q <= PH_CONFIRMED;
							end else begin
								phase_q <= PH_IDLE;
							end
						end
						PH_CONFIRMED: phase_q <= PH_SETTLE;
						PH_SETTLE: if ((now_q - taptime_q) > {16'd0, settle_q}
							&& amag < rebound_q) phase_q <= PH_IDLE;
						default: phase_q <= PH_IDLE;
					endcase
				end
				ST_OUT: if (m_axis_tready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q <= s_axis_tdata[15:0];
			ay_q <= s_axis_tdata[31:16];
			az_q <= s_axis_tdata[47:32];
			gx_q <= uabs(s_axis_tdata[63:48]);
			gy_q <= uabs(s_axis_tdata[79:64]);
			gz_q <= uabs(s_axis_tdata[95:80]);
			now_q <= s_axis_tdata[127:96];
			clr_q <= s_axis_tdata[128];
		end
		if (st_q == ST_MUL) begin
			unique case (mstep_q)
				2'd0: rhs_q <= {16'd0, peak_q} * {24'd0, cnt_q};
				2'd1: rhs_acc_q <= {16'd0, sum_q} * {32'd0, ratio_q};
				default: rhs_acc_q <= rhs_acc_q;
			endcase
		end
		if (st_q == ST_DEC)
			out_q <= {dur, pk_n, mot_n, ph_n, rsn, swing, tap};
	end
endmodule
`default_nettype wire

### sim/imu_tap_swing_classifier_tb.sv
`timescale 1ns / 1ps

module imu_tap_swing_classifier_tb;
	import itsc_pkg::*;

	typedef struct packed {
		bit [31:0] dur;
		bit [15:0] peak;
		bit        motion;
		bit [2:0]  phase;
		bit [1:0]  reason;
		bit        swing;
		bit        tap;
	} tap_result_t;

	class tap_swing_scoreboard;
		bit [15:0] acc_th, gyr_th, max_dur, settle_ms, rebound, sharp;
		bit [7:0]  ratio;
		bit [14:0] gap;
		bit [2:0]  ph, dir_main;
		bit [31:0] t_start, t_tap;
		bit [15:0] peak, prev_mag;
		bit [23:0] msum;
		bit [7:0]  cnt, consist, changes;
		bit        motion;
		tap_result_t expected_results[$];
		int        mismatches;

		function new();
			acc_th = 4096; gyr_th = 2048; max_dur = 150; settle_ms = 200;
			rebound = 2048; ratio = 24; sharp = 512; gap = 256;
			ph = PH_IDLE; dir_main = DIR_NONE; t_start = 0; t_tap = 0;
			peak = 0; prev_mag = 0; msum = 0; cnt = 0; consist = 0; changes = 0;
			motion = 0; mismatches = 0;
		endfunction

		function void write_reg(bit [2:0] idx, bit [15:0] v);
			case (idx)
				REG_ACCEL:   acc_th = v;
				REG_GYRO:    gyr_th = v;
				REG_MAXDUR:  max_dur = v;
				REG_SETTLE:  settle_ms = v;
				REG_REBOUND: rebound = v;
				REG_RATIO:   ratio = v[7:0];
				REG_SHARP:   sharp = v;
				REG_GAP:     gap = v[14:0];
				default: ;
			endcase
		endfunction

		static function int iabs(int v);
			return v < 0 ? -v : v;
		endfunction

		static function bit [15:0] vec_mag(int a, int b, int c);
			longint sq, r, t;
			sq = longint'(a) * a + longint'(b) * b + longint'(c) * c;
			r = 0;
			for (int i = 15; i >= 0; i--) begin
				t = r | (longint'(1) << i);
				if (t * t <= sq)
					r = t;
			end
			return r[15:0];
		endfunction

		static function int axis_mag(bit [2:0] dr, int ax, int ay, int az);
			case (dr)
				DIR_PX, DIR_NX: return ax;
				DIR_PY, DIR_NY: return ay;
				DIR_PZ, DIR_NZ: return az;
				default: return 0;
			endcase
		endfunction

		function bit [2:0] dominant_axis(int x, int y, int z, bit [2:0] last);
			int ax, ay, az, dd;
			bit [2:0] cur;
			ax = iabs(x); ay = iabs(y); az = iabs(z);
			if (ax >= ay && ax >= az)
				cur = x > 0 ? DIR_PX : DIR_NX;
			else if (ay >= ax && ay >= az)
				cur = y > 0 ? DIR_PY : DIR_NY;
			else
				cur = z > 0 ? DIR_PZ : DIR_NZ;
			// A nearby competing axis does not override the held direction.
			if (cur != last && last >= DIR_PX && last <= DIR_NZ) begin
				dd = iabs(axis_mag(cur, ax, ay, az) - axis_mag(last, ax, ay, az));
				if (dd < int'(gap))
					cur = last;
			end
			return cur;
		endfunction

		function void note_sample(bit [135:0] s);
			int ax, ay, az;
			bit [15:0] amag, gmag, delta;
			bit [2:0] dr;
			bit [31:0] now, elapsed;
			bit decided, ok;
			longint lhs, rhs;
			tap_result_t r;
			r = '0;
			decided = 0;
			ax = $signed(s[15:0]); ay = $signed(s[31:16]); az = $signed(s[47:32]);
			now = s[127:96];
			if (s[128])
				motion = 0;
			amag = vec_mag(ax, ay, az);
			gmag = vec_mag($signed(s[63:48]), $signed(s[79:64]), $signed(s[95:80]));
			dr = dominant_axis(ax, ay, az, dir_main);
			delta = amag > prev_mag ? amag - prev_mag : prev_mag - amag;
			prev_mag = amag;
			elapsed = now - t_start;
			case (ph)
				PH_IDLE: begin
					if (amag > acc_th && gmag > gyr_th) begin
						t_start = now; peak = amag; msum = amag; cnt = 1;
						dir_main = dr; consist = 1; changes = 0;
						ph = PH_POTENTIAL;
					end
				end
				PH_POTENTIAL: begin
					if (elapsed > max_dur) begin
						r.swing = 1; r.reason = RSN_LONG; r.dur = elapsed;
						ph = PH_IDLE; motion = 1; decided = 1;
					end
					if (!decided && dr != dir_main) begin
						if (changes < 255)
							changes++;
						dir_main = dr;
						if (changes >= CHANGE_LIMIT) begin
							r.swing = 1; r.reason = RSN_CHANGE; r.dur = elapsed;
							ph = PH_IDLE; motion = 1; decided = 1;
						end
					end
					if (!decided) begin
						if (2 * int'(amag) > int'(acc_th) && 2 * int'(gmag) > int'(gyr_th)) begin
							if (cnt < 255) begin
								cnt++;
								msum = msum + amag;
							end
							if (amag > peak)
								peak = amag;
							if (dr == dir_main) begin
								if (consist < 255)
									consist++;
								if (consist >= CONSIST_LIMIT)
									ph = PH_DIRECTION;
							end else begin
								consist = 0;
							end
						end else begin
							ph = PH_IDLE;
						end
					end
				end
				PH_DIRECTION: begin
					lhs = longint'(peak) * cnt * 16;
					rhs = longint'(msum) * ratio;
					ok = lhs > rhs && longint'(peak) * 5 > longint'(acc_th) * 6 && delta > sharp;
					r.dur = elapsed;
					motion = 1;
					if (ok) begin
						r.tap = 1; t_tap = now; ph = PH_CONFIRMED;
					end else begin
						r.swing = 1; r.reason = RSN_SHARP; ph = PH_IDLE;
					end
				end
				PH_CONFIRMED: ph = PH_SETTLE;
				PH_SETTLE: begin
					if ((now - t_tap) > settle_ms && amag < rebound)
						ph = PH_IDLE;
				end
				default: ph = PH_IDLE;
			endcase
			r.phase = ph;
			r.motion = motion;
			r.peak = peak;
			expected_results.push_back(r);
		endfunction

		function void check_result(bit [55:0] m);
			tap_result_t e, a;
			a = m;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: %h", m);
				return;
			end
			e = expected_results.pop_front();
			if (a.tap != e.tap || a.swing != e.swing || a.reason != e.reason ||
					a.phase != e.phase || a.motion != e.motion || a.peak != e.peak ||
					a.dur != e.dur) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp tap=%0d swing=%0d rsn=%0d ph=%0d mot=%0d peak=%0d dur=%0d | got tap=%0d swing=%0d rsn=%0d ph=%0d mot=%0d peak=%0d dur=%0d",
						e.tap, e.swing, e.reason, e.phase, e.motion, e.peak, e.dur,
						a.tap, a.swing, a.reason, a.phase, a.motion, a.peak, a.dur);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_data;

	tap_swing_scoreboard sb = new();
	bit        idling_on = 1;
	bit [31:0] now_ms;
	int        n_sent;
	int        stall_left;

	imu_tap_swing_classifier i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: random stall bursts while idling_on is set, else always ready; check every accepted transaction.
	initial begin
		m_axis_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!idling_on) begin
				m_axis_tready = 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				m_axis_tready = 1'b0;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				m_axis_tready = 1'b1;
			end
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	task automatic send_sample(bit [135:0] s);
		int gap_len;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap_len = $urandom_range(1, 3);
			repeat (gap_len) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = s;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_sample(s);
		n_sent++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic put(int ax, int ay, int az, int gx, int gy, int gz, bit [31:0] t, bit clr);
		bit [135:0] s;
		s = '0;
		s[15:0] = ax[15:0]; s[31:16] = ay[15:0]; s[47:32] = az[15:0];
		s[63:48] = gx[15:0]; s[79:64] = gy[15:0]; s[95:80] = gz[15:0];
		s[127:96] = t;
		s[128] = clr;
		now_ms = t;
		send_sample(s);
	endtask

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// One sample with a chosen magnitude on a chosen accel axis and on a random gyro axis, over jitter on the rest.
	task automatic emit(int axis, bit neg, int mag, int gmag, int step);
		int a[3];
		int g[3];
		a[0] = jitter(800); a[1] = jitter(800); a[2] = jitter(800);
		g[0] = jitter(800); g[1] = jitter(800); g[2] = jitter(800);
		a[axis] = neg ? -mag : mag;
		g[$urandom_range(0, 2)] = $urandom_range(0, 1) ? -gmag : gmag;
		if ($urandom_range(0, 49) == 0)
			now_ms = $urandom;
		else
			now_ms = now_ms + step;
		put(a[0], a[1], a[2], g[0], g[1], g[2], now_ms, $urandom_range(0, 7) == 0);
	endtask

	task automatic tap_sequence();
		int axis, n, peak_at;
		bit neg;
		axis = $urandom_range(0, 2);
		neg = $urandom_range(0, 1);
		n = $urandom_range(2, 5);
		peak_at = $urandom_range(0, n);
		for (int i = 0; i <= n; i++)
			emit(axis, neg, i == peak_at ? $urandom_range(15000, 32767) : $urandom_range(4000, 9000),
				$urandom_range(1500, 20000), $urandom_range(1, 30));
		emit(axis, neg, $urandom_range(0, 32767), $urandom_range(0, 20000), $urandom_range(1, 30));
		repeat ($urandom_range(2, 6))
			emit($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 3000),
				$urandom_range(0, 2000), $urandom_range(20, 120));
	endtask

	task automatic swing_sequence();
		repeat ($urandom_range(2, 8))
			emit($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(5000, 32767),
				$urandom_range(1500, 30000), $urandom_range(1, 60));
	endtask

	task automatic noise_sample();
		bit [135:0] s;
		s = {$urandom, $urandom, $urandom, $urandom, $urandom};
		s[135:129] = '0;
		now_ms = s[127:96];
		send_sample(s);
	endtask

	task automatic set_reg(bit [2:0] idx, int v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, v[15:0]);
	endtask

	task automatic wait_drained();
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic configure(int p);
		case (p)
			1: begin
				set_reg(REG_ACCEL, 0); set_reg(REG_GYRO, 0); set_reg(REG_MAXDUR, 0);
				set_reg(REG_SETTLE, 0); set_reg(REG_REBOUND, 0); set_reg(REG_RATIO, 0);
				set_reg(REG_SHARP, 0); set_reg(REG_GAP, 0);
			end
			2: begin
				set_reg(REG_ACCEL, 65535); set_reg(REG_GYRO, 65535); set_reg(REG_MAXDUR, 65535);
				set_reg(REG_SETTLE, 65535); set_reg(REG_REBOUND, 65535); set_reg(REG_RATIO, 255);
				set_reg(REG_SHARP, 65535); set_reg(REG_GAP, 32767);
			end
			3: begin
				// Low thresholds with the maximal event duration keep long events alive.
				set_reg(REG_ACCEL, $urandom_range(0, 3000)); set_reg(REG_GYRO, $urandom_range(0, 1000));
				set_reg(REG_MAXDUR, 65535); set_reg(REG_SETTLE, $urandom_range(0, 50));
				set_reg(REG_REBOUND, 65535); set_reg(REG_RATIO, $urandom_range(0, 20));
				set_reg(REG_SHARP, $urandom_range(0, 200)); set_reg(REG_GAP, $urandom_range(0, 100));
			end
			default: begin
				set_reg(REG_ACCEL, $urandom_range(2000, 12000));
				set_reg(REG_GYRO, $urandom_range(1000, 6000));
				set_reg(REG_MAXDUR, $urandom_range(50, 300));
				set_reg(REG_SETTLE, $urandom_range(0, 300));
				set_reg(REG_REBOUND, $urandom_range(1000, 40000));
				set_reg(REG_RATIO, $urandom_range(0, 48));
				set_reg(REG_SHARP, $urandom_range(0, 4000));
				set_reg(REG_GAP, $urandom_range(0, 2000));
			end
		endcase
	endtask

	initial begin
		int target, kind;
		bit paused;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ACCEL;
		cfg_data = '0;
		now_ms = 0;
		n_sent = 0;
		paused = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples under the reset settings.
		put(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1);
		put(32767, 32767, 32767, 32767, 32767, 32767, 1, 0);
		put(0, 0, 0, 0, 0, 0, 2, 0);
		put(8000, 0, 0, 4000, 0, 0, 10, 0);
		put(6000, 0, 0, 3000, 0, 0, 11, 0);
		put(30000, 0, 0, 3000, 0, 0, 12, 0);
		put(2000, 0, 0, 0, 0, 0, 13, 0);
		put(100, 0, 0, 0, 0, 0, 14, 0);
		put(100, 0, 0, 0, 0, 0, 300, 1);
		put(0, -8000, 0, 0, -4000, 0, 400, 0);
		put(0, -8000, 0, 0, -4000, 0, 600, 0);
		put(0, 0, 8000, 0, 0, 4000, 700, 0);
		put(0, 8000, 0, 0, 0, 4000, 701, 0);
		put(0, 0, -8000, 0, 0, 4000, 702, 0);
		put(0, 8000, 0, 0, 0, 4000, 703, 0);
		put(8000, 0, 0, 4000, 0, 0, 800, 0);
		put(8000, 0, 0, 4000, 0, 0, 801, 0);
		put(8000, 0, 0, 4000, 0, 0, 802, 0);
		put(8000, 0, 0, 4000, 0, 0, 803, 0);
		put(9000, 9000, 0, 4000, 4000, 4000, 32'hFFFF_FFF0, 1);
		put(9000, 9100, 0, 4000, 4000, 4000, 32'hFFFF_FFFF, 0);
		put(-9000, 100, 0, 4000, 0, 0, 5, 0);

		for (int p = 0; p < 6; p++) begin
			wait_drained();
			if (p > 0)
				configure(p);
			idling_on = (p != 5);
			target = n_sent + 300;
			while (n_sent < target) begin
				if (p == 3 && !paused && n_sent > target - 200) begin
					// Hold off the sender until the block has returned every result.
					paused = 1;
					while (sb.expected_results.size() != 0)
						@(posedge clk);
				end
				kind = $urandom_range(0, 9);
				if (kind <= 5)
					tap_sequence();
				else if (kind <= 7)
					swing_sequence();
				else if (kind == 8)
					noise_sample();
				else
					emit($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 2000),
						$urandom_range(0, 2000), $urandom_range(1, 200));
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
